/* rtl/low_battery_stepdown_guard_core_macros.svh */
// Assertion macros for the battery guard core.
// Bodies are empty when NO_ASSERTIONS is set.
`ifndef LOW_BATTERY_STEPDOWN_GUARD_CORE_MACROS_SVH
`define LOW_BATTERY_STEPDOWN_GUARD_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked on clk_i, off while rst_ni is low.
`define LBSG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lbsg assertion failed");
// Same check with an explicit clock and active-low reset.
`define LBSG_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("lbsg assertion failed");
`else
`define LBSG_ASSERT(lbl, prop)
`define LBSG_ASSERT_CLK(lbl, clk, rstn, prop)
`endif

`endif

/* rtl/lbsg_pkg.sv */
package lbsg_pkg;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_FIXED   = 2'd1,
    CMD_RAMP    = 2'd2,
    CMD_RESTORE = 2'd3
  } lbsg_cmd_e;

  typedef enum logic {
    REG_START_LIMIT = 1'b0,
    REG_START_THRES = 1'b1
  } lbsg_reg_e;

  localparam int unsigned RegIdxW = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [3:0]  ALERT_DELAY      = 4'd10;
  localparam logic [3:0]  ALERT_TOP        = 4'd11;
  localparam logic [3:0]  FAULT_DELAY      = 4'd2;
  localparam logic [3:0]  RAMP_FAULT_DELAY = 4'd4;
  localparam logic [3:0]  RECOVERY_TOP     = 4'd9;
  localparam logic [15:0] LIMIT_FLOOR      = 16'd500;
  localparam logic [15:0] LIMIT_STEP       = 16'd250;
  localparam logic [15:0] THRES_FLOOR      = 16'd2850;
  localparam logic [15:0] THRES_DOWN       = 16'd25;
  localparam logic [15:0] THRES_UP         = 16'd50;
  localparam logic [15:0] START_LIMIT_RST  = 16'd0;
  localparam logic [15:0] START_THRES_RST  = 16'd2850;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        battery_alert;
    logic        battery_fault;
    logic        charge_high;
    logic        key_click;
    logic        key_hold;
    logic        need_shutoff;
    logic [4:0]  jump_mode;
    logic [15:0] gear_current_ma;
    logic [15:0] mode_threshold_mv;
  } lbsg_in_t;

  typedef struct packed {
    logic        shut_off;
    logic        switch_gear;
    logic [4:0]  target_mode;
    logic [15:0] current_limit_ma;
    logic [15:0] threshold_mv;
  } lbsg_out_t;

  typedef struct packed {
    logic [3:0]  alert_timer;
    logic [3:0]  recovery_timer;
    logic [15:0] ramp_limit;
    logic [15:0] ramp_threshold;
  } lbsg_state_t;

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

endpackage

/* rtl/low_battery_stepdown_guard_core.sv */
// Each item passes through the input register, then the result register.
// Throughput: one item per cycle; the step stage stalls only while the result register is held.
// The state update is a single pass of compare/add logic between the two registers.
// Reset (async, active low): both stages empty, timers cleared, ramp limit 0 mA and
// ramp threshold 2850 mV. Config writes reload the ramp limit or threshold at once.
`include "low_battery_stepdown_guard_core_macros.svh"

module low_battery_stepdown_guard_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // command channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  lbsg_pkg::lbsg_in_t                   in_data_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output lbsg_pkg::lbsg_out_t                  out_data_o,
  // config write port
  input  logic                                 cfg_we_i,
  input  logic [lbsg_pkg::RegIdxW-1:0]         cfg_idx_i,
  input  logic [lbsg_pkg::CfgDataW-1:0]        cfg_wdata_i
);

  // ---------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------
  logic                  item_vld;
  lbsg_pkg::lbsg_in_t    item;
  logic                  out_free;
  logic                  move;
  logic                  out_vld_q, out_vld_d;

  // result register can take a new transfer when empty or being drained
  assign out_free = !out_vld_q || !out_stall_i;
  assign move     = item_vld && out_free;

  lbsg_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .take_i     (out_free),
    .item_vld_o (item_vld),
    .item_o     (item)
  );

  // ---------------------------------------------------------------
  // Guard state: timers and ramp limits
  // ---------------------------------------------------------------
  lbsg_pkg::lbsg_state_t state_q, state_d, state_step;
  lbsg_pkg::lbsg_out_t   res;

  lbsg_step u_step (
    .item_i  (item),
    .state_i (state_q),
    .state_o (state_step),
    .res_o   (res)
  );

  // The user keeps config writes to idle so they never race a step; the core does not check.
  always_comb begin
    state_d = state_q;
    if (move) begin
      state_d = state_step;
    end
    if (cfg_we_i) begin
      case (cfg_idx_i)
        lbsg_pkg::REG_START_LIMIT: state_d.ramp_limit     = cfg_wdata_i;
        lbsg_pkg::REG_START_THRES: state_d.ramp_threshold = cfg_wdata_i;
        default:                   state_d = state_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.alert_timer    <= '0;
      state_q.recovery_timer <= '0;
      state_q.ramp_limit     <= lbsg_pkg::START_LIMIT_RST;
      state_q.ramp_threshold <= lbsg_pkg::START_THRES_RST;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------
  lbsg_pkg::lbsg_out_t out_q;

  assign out_vld_d = move || (out_vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------
  `LBSG_ASSERT(a_alert_timer_cap, state_q.alert_timer <= lbsg_pkg::ALERT_TOP)
  `LBSG_ASSERT(a_recovery_timer_cap, state_q.recovery_timer <= lbsg_pkg::RECOVERY_TOP)
  `LBSG_ASSERT(a_one_request, out_vld_q |-> !(out_q.shut_off && out_q.switch_gear))
  `LBSG_ASSERT(a_target_only_on_switch,
               (out_vld_q && out_q.target_mode != '0) |-> out_q.switch_gear)
  `LBSG_ASSERT(a_state_holds_when_idle, (!move && !cfg_we_i) |=> $stable(state_q))

endmodule

/* rtl/lbsg_in_reg.sv */
// Input register: holds one accepted item until the step stage takes it.
module lbsg_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lbsg_pkg::lbsg_in_t in_data_i,
  input  logic              take_i,
  output logic              item_vld_o,
  output lbsg_pkg::lbsg_in_t item_o
);

  logic               vld_q, vld_d;
  lbsg_pkg::lbsg_in_t data_q;
  logic               load;

  // stall only while a held item cannot move on
  assign in_stall_o = vld_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;
  assign vld_d      = load || (vld_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_data_i;
    end
  end

  assign item_vld_o = vld_q;
  assign item_o     = data_q;

endmodule

/* rtl/lbsg_step.sv */
// One command against the guard state: next state and result fields.
module lbsg_step (
  input  lbsg_pkg::lbsg_in_t    item_i,
  input  lbsg_pkg::lbsg_state_t state_i,
  output lbsg_pkg::lbsg_state_t state_o,
  output lbsg_pkg::lbsg_out_t   res_o
);

  logic        changing;
  logic [3:0]  thr;
  logic        due;
  lbsg_pkg::lbsg_state_t s;
  logic        off, sw;
  logic [4:0]  target;

  assign changing = item_i.key_click || item_i.key_hold;

  always_comb begin
    s      = state_i;
    off    = 1'b0;
    sw     = 1'b0;
    target = '0;
    thr    = lbsg_pkg::FAULT_DELAY;
    due    = 1'b1;
    case (item_i.cmd)
      lbsg_pkg::CMD_TICK: begin
        if (s.recovery_timer != '0 && s.recovery_timer < lbsg_pkg::RECOVERY_TOP) begin
          s.recovery_timer = s.recovery_timer + 4'd1;
        end
        if (s.alert_timer != '0 && s.alert_timer < lbsg_pkg::ALERT_TOP) begin
          s.alert_timer = s.alert_timer + 4'd1;
        end
      end
      lbsg_pkg::CMD_FIXED: begin
        if (!item_i.battery_fault) begin
          thr = lbsg_pkg::ALERT_DELAY;
          if (!item_i.battery_alert || changing) begin
            s.alert_timer = '0;
          end else if (s.alert_timer == '0) begin
            s.alert_timer = 4'd1;
          end
        end else if (s.alert_timer == '0) begin
          s.alert_timer = 4'd1;
        end
        if (s.alert_timer > thr) begin
          if (item_i.need_shutoff || (changing && item_i.battery_fault)) begin
            off = 1'b1;
          end else begin
            s.alert_timer = '0;
            sw            = 1'b1;
            target        = item_i.jump_mode;
          end
        end
      end
      lbsg_pkg::CMD_RAMP: begin
        if (!item_i.battery_alert && !item_i.battery_fault) begin
          s.alert_timer = '0;
          if (item_i.charge_high) begin
            if (s.ramp_limit < item_i.gear_current_ma) begin
              if (s.recovery_timer == '0) begin
                s.recovery_timer = 4'd1;
              end else if (s.recovery_timer < lbsg_pkg::RECOVERY_TOP) begin
                due = 1'b0;
              end
              if (due) begin
                s.recovery_timer = 4'd1;
                if (s.ramp_threshold > item_i.mode_threshold_mv) begin
                  s.ramp_threshold = item_i.mode_threshold_mv;
                end else begin
                  s.ramp_threshold = lbsg_pkg::sat_add16(s.ramp_threshold,
                                                          lbsg_pkg::THRES_UP);
                end
                // limit is below gear here, so it always steps up
                s.ramp_limit = lbsg_pkg::sat_add16(s.ramp_limit, lbsg_pkg::LIMIT_STEP);
              end
            end else begin
              s.recovery_timer = '0;
            end
          end
        end else begin
          s.recovery_timer = '0;
          if (s.alert_timer == '0) begin
            s.alert_timer = 4'd1;
          end
          if (item_i.battery_fault && s.alert_timer > lbsg_pkg::RAMP_FAULT_DELAY) begin
            off = 1'b1;
          end else if (s.alert_timer > lbsg_pkg::ALERT_DELAY) begin
            if (s.ramp_limit > lbsg_pkg::LIMIT_FLOOR) begin
              s.ramp_limit = s.ramp_limit - lbsg_pkg::LIMIT_STEP;
            end
            if (s.ramp_threshold > lbsg_pkg::THRES_FLOOR) begin
              s.ramp_threshold = s.ramp_threshold - lbsg_pkg::THRES_DOWN;
            end
            s.alert_timer = 4'd1;
          end
        end
      end
      lbsg_pkg::CMD_RESTORE: begin
        if (!item_i.battery_alert && !item_i.battery_fault && item_i.charge_high) begin
          s.ramp_limit = item_i.gear_current_ma;
        end
      end
      default: begin
        s = state_i;
      end
    endcase
  end

  assign state_o                = s;
  assign res_o.shut_off         = off;
  assign res_o.switch_gear      = sw;
  assign res_o.target_mode      = target;
  assign res_o.current_limit_ma = s.ramp_limit;
  assign res_o.threshold_mv     = s.ramp_threshold;

endmodule

/* test/tb.sv */
module tb;
  import lbsg_pkg::*;

  // Slowest correct run: ~560 items, each with a drawn gap on the send side, a drawn
  // stall on the result side and its pass through the core. Add the long result hold,
  // the config pauses and the drain waits, then leave a wide margin on top.
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned LongHold   = 80;   // result-side hold that backs the core up
  localparam int unsigned PhaseItems = 90;   // random items per config setting

  // Expected-result tracker: keeps its own copy of the guard state, works out the
  // result of every command transfer and checks the result transfers in order.
  class guard_scoreboard;
    logic [15:0] start_limit_ma;
    logic [15:0] start_thres_mv;
    logic [3:0]  alert_tmr;
    logic [3:0]  recov_tmr;
    logic [15:0] limit_ma;
    logic [15:0] thres_mv;
    lbsg_out_t   expected_q[$];
    int unsigned errors;

    function new();
      start_limit_ma = START_LIMIT_RST;
      start_thres_mv = START_THRES_RST;
      alert_tmr      = '0;
      recov_tmr      = '0;
      limit_ma       = START_LIMIT_RST;
      thres_mv       = START_THRES_RST;
      errors         = 0;
    endfunction

    // A preset write also reloads the matching ramp value right away.
    function void write_reg(lbsg_reg_e idx, logic [15:0] value);
      if (idx == REG_START_LIMIT) begin
        start_limit_ma = value;
        limit_ma       = value;
      end else begin
        start_thres_mv = value;
        thres_mv       = value;
      end
    endfunction

    function logic [15:0] add_clip(logic [15:0] a, logic [15:0] b);
      logic [16:0] total;
      total = {1'b0, a} + {1'b0, b};
      return total[16] ? 16'hFFFF : total[15:0];
    endfunction

    function lbsg_out_t guard_step(lbsg_in_t c);
      lbsg_out_t  res;
      logic       changing;
      logic [3:0] delay;
      res      = '0;
      changing = c.key_click | c.key_hold;
      case (c.cmd)
        CMD_TICK: begin
          if (recov_tmr != 0 && recov_tmr < RECOVERY_TOP) recov_tmr++;
          if (alert_tmr != 0 && alert_tmr < ALERT_TOP) alert_tmr++;
        end
        CMD_FIXED: begin
          delay = FAULT_DELAY;
          if (!c.battery_fault) begin
            delay = ALERT_DELAY;
            if (!c.battery_alert || changing) alert_tmr = '0;
            else if (alert_tmr == 0) alert_tmr = 4'd1;
          end else if (alert_tmr == 0) begin
            alert_tmr = 4'd1;
          end
          if (alert_tmr > delay) begin
            if (c.need_shutoff || (changing && c.battery_fault)) begin
              res.shut_off = 1'b1;
            end else begin
              alert_tmr       = '0;
              res.switch_gear = 1'b1;
              res.target_mode = c.jump_mode;
            end
          end
        end
        CMD_RAMP: begin
          if (!c.battery_alert && !c.battery_fault) begin
            alert_tmr = '0;
            if (c.charge_high) begin
              if (limit_ma < c.gear_current_ma) begin
                // a stopped timer steps at once; a running one waits for its top
                if (recov_tmr == 0 || recov_tmr >= RECOVERY_TOP) begin
                  recov_tmr = 4'd1;
                  if (thres_mv > c.mode_threshold_mv) thres_mv = c.mode_threshold_mv;
                  else thres_mv = add_clip(thres_mv, THRES_UP);
                  if (limit_ma > c.gear_current_ma) limit_ma = c.gear_current_ma;
                  else limit_ma = add_clip(limit_ma, LIMIT_STEP);
                end
              end else begin
                recov_tmr = '0;
              end
            end
          end else begin
            recov_tmr = '0;
            if (alert_tmr == 0) alert_tmr = 4'd1;
            if (c.battery_fault && alert_tmr > RAMP_FAULT_DELAY) begin
              res.shut_off = 1'b1;
            end else if (alert_tmr > ALERT_DELAY) begin
              if (limit_ma > LIMIT_FLOOR) limit_ma = limit_ma - LIMIT_STEP;
              if (thres_mv > THRES_FLOOR) thres_mv = thres_mv - THRES_DOWN;
              alert_tmr = 4'd1;
            end
          end
        end
        default: begin
          if (!c.battery_alert && !c.battery_fault && c.charge_high)
            limit_ma = c.gear_current_ma;
        end
      endcase
      res.current_limit_ma = limit_ma;
      res.threshold_mv     = thres_mv;
      return res;
    endfunction

    function void note_command(lbsg_in_t c);
      expected_q.push_back(guard_step(c));
    endfunction

    function void cmp_field(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_output(lbsg_out_t got);
      lbsg_out_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result with none outstanding, expected nothing, got %h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      cmp_field("shut_off", want.shut_off, got.shut_off);
      cmp_field("switch_gear", want.switch_gear, got.switch_gear);
      cmp_field("target_mode", want.target_mode, got.target_mode);
      cmp_field("current_limit_ma", want.current_limit_ma, got.current_limit_ma);
      cmp_field("threshold_mv", want.threshold_mv, got.threshold_mv);
    endfunction

    function int unsigned count();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  lbsg_in_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  lbsg_out_t             out_data_o;
  logic                  cfg_we_i;
  logic [RegIdxW-1:0]    cfg_idx_i;
  logic [CfgDataW-1:0]   cfg_wdata_i;

  guard_scoreboard sb = new();

  bit          tx_idle_on;    // sender may insert gaps
  bit          rx_idle_on;    // receiver may stall
  bit          rx_hold_req;   // receiver: one long hold at its next draw
  int unsigned items_sent;
  int unsigned cycle_count;

  low_battery_stepdown_guard_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb failed");
    $finish;
  end

  // Transfer monitor. Values are sampled at the edge, before any driver update
  // lands, so nothing here depends on process order. Results are checked before
  // the new command is noted: a result at this edge belongs to an older transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_output(out_data_o);
      if (in_valid_i && !in_stall_o) sb.note_command(in_data_i);
    end
  end

  // Result side: before each result draw a random stall (when stalls are on), or the long
  // hold when asked for. The long hold fills the core so that it stalls its input.
  initial begin : result_sink
    int unsigned hold;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        hold        = LongHold;
        rx_hold_req = 1'b0;
      end else begin
        hold = rx_idle_on ? $urandom_range(0, 8) : 0;
      end
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  function automatic lbsg_in_t make_cmd(lbsg_cmd_e c, bit alert, bit fault, bit plenty,
                                        bit click, bit hold, bit off, logic [4:0] jump,
                                        logic [15:0] gear, logic [15:0] mthr);
    lbsg_in_t item;
    item.cmd               = c;
    item.battery_alert     = alert;
    item.battery_fault     = fault;
    item.charge_high       = plenty;
    item.key_click         = click;
    item.key_hold          = hold;
    item.need_shutoff      = off;
    item.jump_mode         = jump;
    item.gear_current_ma   = gear;
    item.mode_threshold_mv = mthr;
    return item;
  endfunction

  // Fully random fields with a fixed command.
  function automatic lbsg_in_t rand_cmd(lbsg_cmd_e c);
    lbsg_in_t    item;
    logic [63:0] raw;
    raw      = {$urandom, $urandom};
    item     = raw[$bits(lbsg_in_t)-1:0];
    item.cmd = c;
    return item;
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
      1:       return 16'($urandom_range(0, 4000));
      default: return 16'($urandom);
    endcase
  endfunction

  // One command transfer, after a drawn gap. Returns at the accepting edge.
  task automatic send_item(lbsg_in_t item);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // Stop sending and wait until every expected result is in.
  // The first edge lets the monitor note a transfer taken at the current edge.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.count() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(lbsg_reg_e idx, logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  // Directed: timer top hold, fixed-mode jump, fault shut-off with key press and
  // with shut-off request, ramp step below the ceiling, restore under an alarm, restore,
  // ramp at the ceiling, ramp under fault, all-ones item.
  task automatic run_directed();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_item(make_cmd(CMD_TICK, 0, 0, 0, 0, 0, 0, 5'd0, 16'h0000, 16'h0000));
    send_item(make_cmd(CMD_FIXED, 0, 0, 0, 0, 0, 0, 5'd0, 16'h0000, 16'h0000));
    send_item(make_cmd(CMD_FIXED, 1, 0, 0, 0, 0, 0, 5'd31, 16'h0000, 16'h0000));
    // one tick more than needed: the alert timer holds at its top
    repeat (11) send_item(make_cmd(CMD_TICK, 0, 0, 0, 0, 0, 0, 5'd0, 16'h0000, 16'h0000));
    send_item(make_cmd(CMD_FIXED, 1, 0, 0, 0, 0, 0, 5'd31, 16'h0000, 16'h0000));
    send_item(make_cmd(CMD_FIXED, 0, 1, 0, 0, 0, 0, 5'd0, 16'h0000, 16'h0000));
    repeat (2) send_item(make_cmd(CMD_TICK, 0, 0, 0, 0, 0, 0, 5'd0, 16'h0000, 16'h0000));
    send_item(make_cmd(CMD_FIXED, 0, 1, 0, 1, 0, 0, 5'd17, 16'h0000, 16'h0000));
    send_item(make_cmd(CMD_FIXED, 0, 1, 0, 0, 1, 1, 5'd9, 16'h0000, 16'h0000));
    send_item(make_cmd(CMD_RAMP, 0, 0, 1, 0, 0, 0, 5'd0, 16'hFFFF, 16'h0000));
    send_item(make_cmd(CMD_RESTORE, 1, 0, 1, 0, 0, 0, 5'd0, 16'd1234, 16'h0000));
    send_item(make_cmd(CMD_RESTORE, 0, 0, 1, 0, 0, 0, 5'd0, 16'hFFFF, 16'hFFFF));
    send_item(make_cmd(CMD_RAMP, 0, 0, 1, 0, 0, 0, 5'd0, 16'hFFFF, 16'hFFFF));
    send_item(make_cmd(CMD_RAMP, 1, 1, 0, 0, 0, 0, 5'd0, 16'hFFFF, 16'hFFFF));
    send_item('1);
  endtask

  // One random scenario. Most are well-formed sequences (check, ticks, check)
  // that let the timers run out; the rest are restores and plain noise.
  task automatic run_scenario();
    int unsigned kind;
    int unsigned reps;
    bit          alert;
    bit          fault;
    bit          plenty;
    bit          click;
    bit          hold;
    bit          off;
    logic [4:0]  jump;
    logic [15:0] gear;
    logic [15:0] mthr;
    tx_idle_on = ($urandom_range(0, 2) != 0);
    rx_idle_on = ($urandom_range(0, 2) != 0);
    kind   = $urandom_range(0, 9);
    fault  = ($urandom_range(0, 2) == 0);
    alert  = fault ? bit'($urandom_range(0, 1)) : ($urandom_range(0, 5) != 0);
    plenty = ($urandom_range(0, 3) != 0);
    click  = ($urandom_range(0, 5) == 0);
    hold   = ($urandom_range(0, 5) == 0);
    off    = ($urandom_range(0, 2) == 0);
    jump   = 5'($urandom);
    gear   = pick16();
    mthr   = pick16();
    reps   = $urandom_range(1, 4);
    if (kind < 3) begin
      // fixed mode: alarm held while ticks run the timer past its delay
      repeat (reps) begin
        send_item(make_cmd(CMD_FIXED, alert, fault, plenty, click, hold, off, jump,
                           gear, mthr));
        repeat (fault ? $urandom_range(0, 4) : $urandom_range(0, 13))
          send_item(rand_cmd(CMD_TICK));
      end
      send_item(make_cmd(CMD_FIXED, alert, fault, plenty, click, hold, off, jump,
                         gear, mthr));
    end else if (kind < 5) begin
      // ramp mode under alarm: step-downs, or shut-off on fault
      if (!fault) alert = 1'b1;
      repeat (reps) begin
        send_item(make_cmd(CMD_RAMP, alert, fault, plenty, click, hold, off, jump,
                           gear, mthr));
        repeat ($urandom_range(fault ? 0 : 8, 12)) send_item(rand_cmd(CMD_TICK));
      end
      send_item(make_cmd(CMD_RAMP, alert, fault, plenty, click, hold, off, jump,
                         gear, mthr));
    end else if (kind < 8) begin
      // ramp recovery: healthy battery, ceiling mostly above the present limit
      plenty = ($urandom_range(0, 7) != 0);
      if ($urandom_range(0, 3) != 0)
        gear = (sb.limit_ma > 16'd62535) ? 16'hFFFF : 16'(sb.limit_ma + $urandom_range(1, 3000));
      if ($urandom_range(0, 1) != 0)
        mthr = (sb.thres_mv > 16'd65235) ? 16'hFFFF : 16'(sb.thres_mv + $urandom_range(0, 300));
      repeat (reps + 1) begin
        send_item(make_cmd(CMD_RAMP, 0, 0, plenty, click, hold, off, jump, gear, mthr));
        repeat ($urandom_range(7, 10)) send_item(rand_cmd(CMD_TICK));
      end
    end else if (kind == 8) begin
      alert = ($urandom_range(0, 3) == 0);
      fault = ($urandom_range(0, 3) == 0);
      send_item(make_cmd(CMD_RESTORE, alert, fault, plenty, click, hold, off, jump,
                         gear, mthr));
    end else begin
      repeat (reps) send_item(rand_cmd(lbsg_cmd_e'($urandom_range(0, 3))));
    end
  endtask

  initial begin
    int unsigned goal;
    bit          held;
    bit          paused;
    logic [15:0] lim;
    logic [15:0] thr;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    out_stall_i <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= REG_START_LIMIT;
    cfg_wdata_i <= '0;
    rst_ni      <= 1'b0;
    tx_idle_on  = 1'b0;
    rx_idle_on  = 1'b0;
    rx_hold_req = 1'b0;
    items_sent  = 0;
    held        = 1'b0;
    paused      = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset presets: limit 0 mA, threshold 2850 mV
    run_directed();

    for (int p = 0; p < 5; p++) begin
      // presets change only with the core empty
      wait_drained();
      case (p)
        0:       begin lim = 16'hFFFF; thr = 16'hFFFF; end
        1:       begin lim = 16'h0000; thr = 16'h0000; end
        2:       begin lim = 16'd65400; thr = 16'd2900; end  // close to saturation
        3:       begin lim = 16'd600; thr = 16'd3000; end    // just above the floors
        default: begin lim = 16'($urandom); thr = 16'($urandom); end
      endcase
      write_reg(REG_START_LIMIT, lim);
      write_reg(REG_START_THRES, thr);
      goal = items_sent + PhaseItems;
      while (items_sent < goal) begin
        if (p == 0 && !held && items_sent + PhaseItems / 2 >= goal) begin
          // long result hold while commands keep coming back to back
          held        = 1'b1;
          rx_hold_req = 1'b1;
          tx_idle_on  = 1'b0;
          repeat (30) send_item(rand_cmd(lbsg_cmd_e'($urandom_range(0, 3))));
        end else if (p == 1 && !paused && items_sent + PhaseItems / 2 >= goal) begin
          // sender goes quiet until everything in flight has come out
          paused = 1'b1;
          wait_drained();
        end else begin
          run_scenario();
        end
      end
    end

    wait_drained();
    if (sb.errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
